// ===== rtl/hab_pkg.sv =====
// ----------------------------------------------------------------------------
// hab_pkg
// Shared types, constants and helper functions for the hemisphere angle bin
// accumulator: item and result structs, queue entry, CORDIC table.
// ----------------------------------------------------------------------------
package hab_pkg;

  localparam int SUM_WIDTH        = 48;
  localparam int ZENITH_BINS_DEF  = 91;
  localparam int AZIMUTH_BINS_DEF = 360;
  localparam int BIN_ADDR_W       = 17;   // covers the largest bin count
  localparam int CORDIC_STEPS     = 16;
  localparam int CORDIC_W         = 36;
  localparam int ACC_W            = 25;
  localparam int DEG_MAX          = 90;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] stokes_i;
    logic signed [15:0] stokes_q;
    logic signed [15:0] stokes_u;
    logic signed [15:0] stokes_v;
    logic [6:0]         read_zenith;
    logic [8:0]         read_azimuth;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] sum_i;
    logic signed [SUM_WIDTH-1:0] sum_q;
    logic signed [SUM_WIDTH-1:0] sum_u;
    logic signed [SUM_WIDTH-1:0] sum_v;
  } result_t;

  // Classified work item handed from front to back
  typedef struct packed {
    logic                  is_read;
    logic                  zero;     // read outside the bin range
    logic [BIN_ADDR_W-1:0] addr;
    logic signed [15:0]    stokes_i;
    logic signed [15:0]    stokes_q;
    logic signed [15:0]    stokes_u;
    logic signed [15:0]    stokes_v;
  } qentry_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic [21:0] atan_entry(input logic [3:0] i);
    logic [21:0] r;
    case (i)
      4'd0:    r = 22'd2949120;
      4'd1:    r = 22'd1740967;
      4'd2:    r = 22'd919879;
      4'd3:    r = 22'd466945;
      4'd4:    r = 22'd234379;
      4'd5:    r = 22'd117304;
      4'd6:    r = 22'd58666;
      4'd7:    r = 22'd29335;
      4'd8:    r = 22'd14668;
      4'd9:    r = 22'd7334;
      4'd10:   r = 22'd3667;
      4'd11:   r = 22'd1833;
      4'd12:   r = 22'd917;
      4'd13:   r = 22'd458;
      4'd14:   r = 22'd229;
      default: r = 22'd115;
    endcase
    return r;
  endfunction

  // Clamp angle to 0..90 degrees and round half up to whole degrees
  function automatic logic [6:0] cordic_to_deg(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] c;
    logic signed [ACC_W-1:0] r;
    c = acc;
    if (c < 0) begin
      c = '0;
    end else if (c > $signed(ACC_W'(DEG_MAX * 65536))) begin
      c = $signed(ACC_W'(DEG_MAX * 65536));
    end
    r = c + $signed(ACC_W'(32768));
    return r[22:16];
  endfunction

  // Saturating add of a 16-bit sample into a sum
  function automatic logic signed [SUM_WIDTH-1:0] sat_add(
    input logic signed [SUM_WIDTH-1:0] s,
    input logic signed [15:0]          v
  );
    logic signed [SUM_WIDTH:0] t;
    t = {s[SUM_WIDTH-1], s} + {{(SUM_WIDTH-15){v[15]}}, v};
    if (t[SUM_WIDTH] != t[SUM_WIDTH-1]) begin
      return t[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end
    return t[SUM_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/hab_front.sv =====
// ----------------------------------------------------------------------------
// hab_front
// Accepts items and classifies them: reads get their bin address, rays with
// z > 0 get their zenith and azimuth bins from an iterative square root and a
// shared iterative CORDIC unit; other rays are dropped.
// ----------------------------------------------------------------------------
module hab_front #(
  parameter int ZENITH_BINS  = hab_pkg::ZENITH_BINS_DEF,
  parameter int AZIMUTH_BINS = hab_pkg::AZIMUTH_BINS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  hab_pkg::in_item_t item,
  output logic              idle,
  input  logic              q_full,
  output logic              q_push,
  output hab_pkg::qentry_t  q_data
);
  import hab_pkg::*;

  localparam int ZLIM = (ZENITH_BINS - 1 < DEG_MAX) ? ZENITH_BINS - 1 : DEG_MAX;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SQRT, S_ZEN, S_AZ, S_PUSH} state_t;

  state_t                     state;
  in_item_t                   it;
  logic [59:0]                n;
  logic [59:0]                res;
  logic [59:0]                bitv;
  logic signed [CORDIC_W-1:0] cx;
  logic signed [CORDIC_W-1:0] cy;
  logic signed [ACC_W-1:0]    acc;
  logic [3:0]                 step;
  logic [6:0]                 theta;
  logic [8:0]                 phi;

  logic signed [31:0]         xx;
  logic signed [31:0]         yy;
  logic [31:0]                sq;
  logic [59:0]                trial;
  logic [59:0]                res_next;
  logic signed [CORDIC_W-1:0] cx_next;
  logic signed [CORDIC_W-1:0] cy_next;
  logic signed [ACC_W-1:0]    acc_next;
  logic [6:0]                 deg;
  logic signed [16:0]         ax;
  logic signed [16:0]         ay;

  // Fold first-quadrant angle into 0..359 by quadrant (x == 0 apart), clamped to the last bin
  function automatic logic [8:0] fold_phi(input logic signed [15:0] x,
                                          input logic signed [15:0] y,
                                          input logic [6:0] a);
    int p;
    if (x == 0) begin
      p = (y > 0) ? 90 : ((y < 0) ? 270 : 0);
    end else if (x > 0) begin
      p = (y >= 0) ? int'(a) : 360 - int'(a);
    end else begin
      p = (y < 0) ? 180 + int'(a) : 180 - int'(a);
    end
    if (p == 360) begin
      p = 0;
    end
    if (p > AZIMUTH_BINS - 1) begin
      p = AZIMUTH_BINS - 1;
    end
    return 9'(p);
  endfunction

  // Squared radius
  assign xx = it.dir_x * it.dir_x;
  assign yy = it.dir_y * it.dir_y;
  assign sq = $unsigned(xx) + $unsigned(yy);

  // One square root digit
  assign trial    = res + bitv;
  assign res_next = (n >= trial) ? ((res >> 1) + bitv) : (res >> 1);

  // One CORDIC vectoring step
  always_comb begin
    if (cy >= 0) begin
      cx_next  = cx + (cy >>> step);
      cy_next  = cy - (cx >>> step);
      acc_next = acc + $signed({3'b000, atan_entry(step)});
    end else begin
      cx_next  = cx - (cy >>> step);
      cy_next  = cy + (cx >>> step);
      acc_next = acc - $signed({3'b000, atan_entry(step)});
    end
  end
  assign deg = cordic_to_deg(acc_next);

  assign ax = it.dir_x[15] ? (17'sd0 - 17'(it.dir_x)) : 17'(it.dir_x);
  assign ay = it.dir_y[15] ? (17'sd0 - 17'(it.dir_y)) : 17'(it.dir_y);

  // Queue entry
  always_comb begin
    q_data          = '0;
    q_data.is_read  = (it.opcode == OP_READ);
    q_data.stokes_i = it.stokes_i;
    q_data.stokes_q = it.stokes_q;
    q_data.stokes_u = it.stokes_u;
    q_data.stokes_v = it.stokes_v;
    if (it.opcode == OP_READ) begin
      q_data.zero = (int'(it.read_zenith) >= ZENITH_BINS) ||
                    (int'(it.read_azimuth) >= AZIMUTH_BINS);
      q_data.addr = q_data.zero ? '0 :
        BIN_ADDR_W'(int'(it.read_zenith) * AZIMUTH_BINS + int'(it.read_azimuth));
    end else begin
      q_data.addr = BIN_ADDR_W'(int'(theta) * AZIMUTH_BINS + int'(phi));
    end
  end

  assign q_push = (state == S_PUSH) && !q_full;
  assign idle   = (state == S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            it <= item;
            if (item.opcode == OP_READ) begin
              state <= S_PUSH;
            end else if (item.dir_z > 0) begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          n     <= {sq, 28'b0};
          res   <= '0;
          bitv  <= 60'(1) << 58;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (n >= trial) begin
            n <= n - trial;
          end
          res  <= res_next;
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            cx    <= CORDIC_W'(it.dir_z) <<< 14;
            cy    <= $signed(CORDIC_W'(res_next));
            acc   <= '0;
            step  <= '0;
            state <= S_ZEN;
          end
        end
        S_ZEN: begin
          if (step == 4'(CORDIC_STEPS - 1)) begin
            theta <= (int'(deg) > ZLIM) ? 7'(ZLIM) : deg;
            if (it.dir_x == 0) begin
              phi   <= fold_phi(it.dir_x, it.dir_y, 7'd0);
              state <= S_PUSH;
            end else begin
              cx    <= CORDIC_W'(ax) <<< 14;
              cy    <= CORDIC_W'(ay) <<< 14;
              acc   <= '0;
              step  <= '0;
              state <= S_AZ;
            end
          end else begin
            cx   <= cx_next;
            cy   <= cy_next;
            acc  <= acc_next;
            step <= step + 4'd1;
          end
        end
        S_AZ: begin
          cx   <= cx_next;
          cy   <= cy_next;
          acc  <= acc_next;
          step <= step + 4'd1;
          if (step == 4'(CORDIC_STEPS - 1)) begin
            phi   <= fold_phi(it.dir_x, it.dir_y, deg);
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!q_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/hab_fifo.sv =====
// ----------------------------------------------------------------------------
// hab_fifo
// Two-entry queue between the classifying front and the bin update back.
// ----------------------------------------------------------------------------
module hab_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hab_pkg::qentry_t data_in,
  output logic             full,
  input  logic             pop,
  output hab_pkg::qentry_t data_out,
  output logic             empty
);
  import hab_pkg::*;

  qentry_t    slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign data_out = slots[rp];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= data_in;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/hab_back.sv =====
// ----------------------------------------------------------------------------
// hab_back
// Bin store and its sequencer: clearing pass after reset, then one queued
// item at a time as a registered read followed by a saturating write or a
// result strobe.
// ----------------------------------------------------------------------------
module hab_back #(
  parameter int ZENITH_BINS  = hab_pkg::ZENITH_BINS_DEF,
  parameter int AZIMUTH_BINS = hab_pkg::AZIMUTH_BINS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  output logic             q_pop,
  input  hab_pkg::qentry_t q_data,
  output logic             clearing,
  output logic             valid,
  output hab_pkg::result_t result
);
  import hab_pkg::*;

  localparam int NBINS = ZENITH_BINS * AZIMUTH_BINS;
  localparam int AW    = $clog2(NBINS);

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_EXEC} state_t;

  result_t         mem [NBINS];
  result_t         rdata;
  state_t          state;
  qentry_t         cur;
  logic [AW-1:0]   clr_cnt;

  logic            we;
  logic [AW-1:0]   waddr;
  result_t         wdata;
  logic            re;

  assign clearing = (state == B_CLEAR);
  assign q_pop    = (state == B_IDLE) && !q_empty;
  assign re       = q_pop && !q_data.zero;

  // Write port select
  always_comb begin
    we    = 1'b0;
    waddr = cur.addr[AW-1:0];
    wdata = '0;
    if (state == B_CLEAR) begin
      we    = 1'b1;
      waddr = clr_cnt;
    end else if (state == B_EXEC && !cur.is_read) begin
      we          = 1'b1;
      wdata.sum_i = sat_add(rdata.sum_i, cur.stokes_i);
      wdata.sum_q = sat_add(rdata.sum_q, cur.stokes_q);
      wdata.sum_u = sat_add(rdata.sum_u, cur.stokes_u);
      wdata.sum_v = sat_add(rdata.sum_v, cur.stokes_v);
    end
  end

  // Bin store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[q_data.addr[AW-1:0]];
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_CLEAR;
      clr_cnt <= '0;
      valid   <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        B_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(NBINS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_empty) begin
            cur   <= q_data;
            state <= B_EXEC;
          end
        end
        B_EXEC: begin
          if (cur.is_read) begin
            valid  <= 1'b1;
            result <= cur.zero ? '0 : rdata;
          end
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/hemisphere_angle_bin_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// hemisphere_angle_bin_accumulator_top
// Angular histogram of Stokes vectors over the upper hemisphere.
// ----------------------------------------------------------------------------
// After reset the block clears its ZENITH_BINS*AZIMUTH_BINS bin store one bin
// per cycle with busy held high. An item is taken when start is high and
// busy is low. A read holds busy until it is pushed into the queue, so the
// next item is taken only after that. A ray holds busy through a squaring
// step, the bit-serial square root, 16 CORDIC iterations for the zenith, 16
// more for the azimuth, which are skipped when x is zero, and the push of the
// bin into the queue; a ray with z <= 0 does not raise busy.
// A two-entry queue feeds the bin update side, which handles each item as a
// read and then a write of the single-port store, so the queue never holds
// the front back. A read result is read from the store, registered and shown
// for one cycle with valid high, and cannot be held off.
module hemisphere_angle_bin_accumulator_top #(
  parameter int ZENITH_BINS  = hab_pkg::ZENITH_BINS_DEF,
  parameter int AZIMUTH_BINS = hab_pkg::AZIMUTH_BINS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  hab_pkg::in_item_t item,
  output logic              valid,
  output hab_pkg::result_t  result
);
  import hab_pkg::*;

  logic    front_idle;
  logic    clearing;
  logic    accept;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  qentry_t q_in;
  qentry_t q_out;

  assign busy   = !front_idle || clearing;
  assign accept = start && !busy;

  // Classifying front
  hab_front #(
    .ZENITH_BINS  (ZENITH_BINS),
    .AZIMUTH_BINS (AZIMUTH_BINS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .idle   (front_idle),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // Work queue
  hab_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .data_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .data_out (q_out),
    .empty    (q_empty)
  );

  // Bin store side
  hab_back #(
    .ZENITH_BINS  (ZENITH_BINS),
    .AZIMUTH_BINS (AZIMUTH_BINS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_data   (q_out),
    .clearing (clearing),
    .valid    (valid),
    .result   (result)
  );

`ifndef ASSERT_OFF
  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !valid) else $error("result during clearing pass");
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("push into full queue");
  a_results_spaced: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid) else $error("back-to-back result strobes");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("pop from empty queue");
`endif

endmodule
